### design/cabs_pkg.sv
package cabs_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int COORD_BITS = 16;
	localparam int LABEL_BITS = 8;
	localparam int THR_W      = 16;
	localparam int IDX_W      = 16;

	localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W  = $clog2(MAX_KEPT + 1);

	localparam int AREA_W = 2 * COORD_BITS;
	localparam int UNI_W  = AREA_W + 1;
	localparam int PROD_W = UNI_W + THR_W;

	localparam int APB_AW = 3;
	localparam logic [APB_AW-3:0] REG_IOU_THR = '0;
	localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(29491);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0]        ext_t;
	typedef logic [LABEL_BITS-1:0]        label_t;
	typedef logic [THR_W-1:0]             thr_t;
	typedef logic [AREA_W-1:0]            area_t;
	typedef logic [UNI_W-1:0]             uni_t;
	typedef logic [PROD_W-1:0]            prod_t;
	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [IDX_W-1:0]             idx_t;

	typedef struct packed {
		coord_t x_min;
		coord_t y_min;
		coord_t x_max;
		coord_t y_max;
		label_t class_label;
		logic   frame_start;
	} in_item_t;

	typedef struct packed {
		logic keep;
		idx_t item_index;
		logic table_full;
	} out_item_t;

	// one table entry: stored box and its class
	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		label_t label;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic busy;   // compare in flight
		logic hit;    // overlap over limit seen this cycle
	} iou_stat_t;

	function automatic coord_t cmax(input coord_t a, input coord_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic coord_t cmin(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

	// hi - lo clamped at zero; the true difference always fits COORD_BITS unsigned
	function automatic ext_t extent(input coord_t lo, input coord_t hi);
		return (hi > lo) ? ext_t'(hi - lo) : '0;
	endfunction

endpackage

### design/cabs_ram.sv
module cabs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/cabs_iou.sv
module cabs_iou (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  cabs_pkg::entry_t    kept,
	input  cabs_pkg::entry_t    probe,
	input  cabs_pkg::area_t     area_a,
	input  cabs_pkg::thr_t      thr,
	output cabs_pkg::iou_stat_t stat
);

	// s1: overlap extents and kept box extents
	logic           vld_s1;
	cabs_pkg::ext_t ix_s1, iy_s1, kw_s1, kh_s1;
	// s2: products
	logic            vld_s2;
	cabs_pkg::area_t inter_s2, area_b_s2;
	// s3: union
	logic            vld_s3;
	cabs_pkg::area_t inter_s3;
	cabs_pkg::uni_t  uni_s3;
	// s4: threshold times union
	logic            vld_s4;
	cabs_pkg::area_t inter_s4;
	cabs_pkg::prod_t prod_s4;

	logic          match;
	cabs_pkg::prod_t lhs;

	assign match = (kept.label == probe.label);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld && match;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ix_s1 <= cabs_pkg::extent(cabs_pkg::cmax(probe.x0, kept.x0),
		                          cabs_pkg::cmin(probe.x1, kept.x1));
		iy_s1 <= cabs_pkg::extent(cabs_pkg::cmax(probe.y0, kept.y0),
		                          cabs_pkg::cmin(probe.y1, kept.y1));
		kw_s1 <= cabs_pkg::extent(kept.x0, kept.x1);
		kh_s1 <= cabs_pkg::extent(kept.y0, kept.y1);

		inter_s2  <= cabs_pkg::area_t'(ix_s1) * cabs_pkg::area_t'(iy_s1);
		area_b_s2 <= cabs_pkg::area_t'(kw_s1) * cabs_pkg::area_t'(kh_s1);

		// intersection never exceeds either area, so this stays non-negative
		inter_s3 <= inter_s2;
		uni_s3   <= cabs_pkg::uni_t'(area_a) + cabs_pkg::uni_t'(area_b_s2)
		            - cabs_pkg::uni_t'(inter_s2);

		inter_s4 <= inter_s3;
		prod_s4  <= cabs_pkg::prod_t'(thr) * cabs_pkg::prod_t'(uni_s3);
	end

	// intersection * 2^16 against threshold * union; zero intersection never wins
	assign lhs = cabs_pkg::prod_t'({inter_s4, {cabs_pkg::THR_W{1'b0}}});

	assign stat.hit  = vld_s4 && (lhs > prod_s4);
	assign stat.busy = vld_s1 || vld_s2 || vld_s3 || vld_s4;

endmodule

### design/class_aware_box_suppression_core.sv
// Class-aware greedy NMS. One box per start beat; one result beat per box.
// Sequence: an accepted box passes PREP, then SCAN over the kept boxes of the
// frame and DRAIN, which waits for the last read and the four-stage compare
// pipeline to empty, then FINISH; with no kept box PREP goes straight to
// FINISH. The result strobe is registered from FINISH.
// Throughput: one box at a time, set by the single read port of the kept
// table (one kept entry compared per cycle). busy is low in the strobe cycle.
// Reset: threshold back to 29491, kept count and frame index cleared; table
// contents are not cleared (entries above the count are never read).
module class_aware_box_suppression_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// command side
	input  logic                              start,
	output logic                              busy,
	input  cabs_pkg::in_item_t                item,
	output logic                              result_valid,
	output cabs_pkg::out_item_t               result,
	// APB config port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cabs_pkg::APB_AW-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PREP   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	cabs_pkg::thr_t    thr_q;
	cabs_pkg::cnt_t    count_q;      // boxes stored this frame
	cabs_pkg::idx_t    fidx_q;       // index of the next box in the frame
	cabs_pkg::idx_t    cur_idx_q;    // index of the box in work
	cabs_pkg::addr_t   ptr_q;        // scan read pointer
	logic              rd_issued_q;  // RAM data valid this cycle
	logic              hit_q;
	cabs_pkg::entry_t  probe_q;
	cabs_pkg::area_t   area_q;
	logic              result_valid_q;
	cabs_pkg::out_item_t result_q;

	logic              accept;
	logic              cfg_wr;
	logic              scan_last;
	logic              keep;
	logic              room;
	logic              ram_we;
	logic [cabs_pkg::ENTRY_W-1:0] ram_rdata;
	cabs_pkg::entry_t  kept;
	cabs_pkg::iou_stat_t stat;
	cabs_pkg::idx_t    idx_base;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
	                && (paddr[cabs_pkg::APB_AW-1:2] == cabs_pkg::REG_IOU_THR);

	always_comb begin
		prdata = '0;
		if (paddr[cabs_pkg::APB_AW-1:2] == cabs_pkg::REG_IOU_THR) begin
			prdata = 32'(thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= cabs_pkg::THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[cabs_pkg::THR_W-1:0];
		end
	end

	// ---------------- control ----------------
	// scan reads entries 0 .. count-1, one per cycle
	assign scan_last = ((cabs_pkg::cnt_t'(ptr_q) + cabs_pkg::cnt_t'(1)) == count_q);
	assign keep      = !hit_q;
	assign room      = (count_q < cabs_pkg::cnt_t'(cabs_pkg::MAX_KEPT));
	assign ram_we    = (state_q == ST_FINISH) && keep && room;
	assign idx_base  = item.frame_start ? '0 : fidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			fidx_q         <= '0;
			ptr_q          <= '0;
			rd_issued_q    <= 1'b0;
			hit_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_issued_q    <= (state_q == ST_SCAN);
			result_valid_q <= (state_q == ST_FINISH);
			if (accept) begin
				hit_q <= 1'b0;
			end else if (stat.hit) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// frame start empties the table before this box by clearing the kept count
						if (item.frame_start) begin
							count_q <= '0;
						end
						fidx_q <= idx_base + cabs_pkg::idx_t'(1);
						ptr_q  <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= (count_q == '0) ? ST_FINISH : ST_SCAN;
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + cabs_pkg::addr_t'(1);
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_issued_q && !stat.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (ram_we) begin
						count_q <= count_q + cabs_pkg::cnt_t'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			probe_q.x0    <= item.x_min;
			probe_q.y0    <= item.y_min;
			probe_q.x1    <= item.x_max;
			probe_q.y1    <= item.y_max;
			probe_q.label <= item.class_label;
			cur_idx_q     <= idx_base;
		end
		if (state_q == ST_PREP) begin
			area_q <= cabs_pkg::area_t'(cabs_pkg::extent(probe_q.x0, probe_q.x1))
			        * cabs_pkg::area_t'(cabs_pkg::extent(probe_q.y0, probe_q.y1));
		end
		if (state_q == ST_FINISH) begin
			result_q.keep       <= keep;
			result_q.item_index <= cur_idx_q;
			result_q.table_full <= keep && !room;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------- kept table ----------------
	// reads only in SCAN, the write only in FINISH: no overlap within an item
	cabs_ram #(
		.WIDTH (cabs_pkg::ENTRY_W),
		.DEPTH (cabs_pkg::MAX_KEPT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[cabs_pkg::ADDR_W-1:0]),
		.wdata (probe_q),
		.re    (state_q == ST_SCAN),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	assign kept = cabs_pkg::entry_t'(ram_rdata);

	// ---------------- overlap test pipeline ----------------
	cabs_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (rd_issued_q),
		.kept   (kept),
		.probe  (probe_q),
		.area_a (area_q),
		.thr    (thr_q),
		.stat   (stat)
	);

endmodule
